[hdl/assert_macros.svh]
// ----------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mixer.
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SEMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("semx: same-cycle check failed");

// next-cycle implication
`define SEMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("semx: next-cycle check failed");

`endif

[hdl/semx_pkg.sv]
// ----------------------------------------------------------------
// semx_pkg
// Types and constants of the sample-playback voice mixer.
// ----------------------------------------------------------------
package semx_pkg;

	localparam int OPCODE_W  = 2;
	localparam int EFF_ID_W  = 3;
	localparam int ADDR_W    = 15;
	localparam int DATA_W    = 16;
	localparam int LEN_W     = 16;
	localparam int OUT_W     = 19;
	localparam int NUM_LEN_REGS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_MAX   = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN   = -(2 ** (OUT_W - 1));

	localparam int NUM_VOICES_DEF  = 8;
	localparam int NUM_EFFECTS_DEF = 8;
	localparam int MAX_LEN_DEF     = 32768;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_PLAY = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic do_load;
		logic do_play;
		logic scan_start;
		logic scan_step;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

[hdl/semx_ram.sv]
// ----------------------------------------------------------------
// semx_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------
module semx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/semx_ctrl.sv]
// ----------------------------------------------------------------
// semx_ctrl
// Sequencer: decodes requests and walks a tick through the voices.
// ----------------------------------------------------------------
module semx_ctrl import semx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  sts_t                sts,
	output cmd_t                cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && opcode == OP_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				case (opcode)
					OP_LOAD: cmd.do_load    = in_valid;
					OP_PLAY: cmd.do_play    = in_valid;
					OP_TICK: cmd.scan_start = in_valid;
					default: ;
				endcase
			end
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_DRAIN: ;
			ST_EMIT:  cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

[hdl/semx_dp.sv]
// ----------------------------------------------------------------
// semx_dp
// Voice table, length registers, sample memory, accumulator and
// output register.
// ----------------------------------------------------------------
module semx_dp import semx_pkg::*; #(
	parameter int NUM_VOICES  = NUM_VOICES_DEF,
	parameter int NUM_EFFECTS = NUM_EFFECTS_DEF,
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [EFF_ID_W-1:0]      effect_id,
	input  logic [ADDR_W-1:0]        sample_addr,
	input  logic signed [DATA_W-1:0] sample_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [LEN_W-1:0]         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  mixed_sample
);

	localparam int VIDX_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int MEM_DEPTH = NUM_EFFECTS * MAX_LEN;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int POS_W     = $clog2(MAX_LEN);
	localparam int CLEN_W    = $clog2(MAX_LEN + 1);
	localparam int EXT_W     = (SAMPLE_BITS > DATA_W) ? SAMPLE_BITS : DATA_W;
	localparam int SUM_W     = SAMPLE_BITS + $clog2(NUM_VOICES) + 1;
	localparam int ACC_W     = (SUM_W > OUT_W) ? SUM_W : OUT_W + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

	logic [LEN_W-1:0]    len_q [NUM_LEN_REGS];
	logic [NUM_VOICES-1:0] active_q;
	logic [EFF_ID_W-1:0] eff_q [NUM_VOICES];
	logic [POS_W-1:0]    pos_q [NUM_VOICES];
	logic [VIDX_W-1:0]   vcnt_q;
	logic                rd_valid_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic                out_valid_q;
	logic signed [OUT_W-1:0] out_q;

	// ---- length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEN_REGS; i++) begin
				len_q[i] <= '0;
			end
		end else if (cfg_we) begin
			len_q[cfg_index] <= cfg_data;
		end
	end

	// ---- current voice of a tick
	logic                cur_act;
	logic [EFF_ID_W-1:0] cur_eff;
	logic [POS_W-1:0]    cur_pos;
	logic [LEN_W-1:0]    cur_len_raw;
	logic [CLEN_W-1:0]   cur_len;
	logic [CLEN_W-1:0]   cur_pos_x;
	logic [CLEN_W-1:0]   cur_pos_inc;
	logic                cur_bad;
	logic                cur_read;
	logic                cur_done;

	always_comb begin
		cur_act     = active_q[vcnt_q];
		cur_eff     = eff_q[vcnt_q];
		cur_pos     = pos_q[vcnt_q];
		cur_len_raw = len_q[cur_eff];
		// lengths above the table size act as the table size
		if ({1'b0, cur_len_raw} > 17'(MAX_LEN)) begin
			cur_len = CLEN_W'(MAX_LEN);
		end else begin
			cur_len = CLEN_W'(cur_len_raw);
		end
		cur_pos_x   = CLEN_W'(cur_pos);
		cur_pos_inc = cur_pos_x + CLEN_W'(1);
		cur_bad     = ({1'b0, cur_eff} >= 4'(NUM_EFFECTS)) || (cur_pos_x >= cur_len);
		cur_read    = cmd.scan_step && cur_act && !cur_bad;
		cur_done    = cur_pos_inc >= cur_len;
	end

	// ---- first idle voice for a play request
	logic              play_hit;
	logic [VIDX_W-1:0] play_idx;
	logic              play_ok;

	always_comb begin
		play_hit = 1'b0;
		play_idx = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				play_hit = 1'b1;
				play_idx = VIDX_W'(v);
			end
		end
		play_ok = cmd.do_play && play_hit && ({1'b0, effect_id} < 4'(NUM_EFFECTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (play_ok) begin
			active_q[play_idx] <= 1'b1;
		end else if (cmd.scan_step && cur_act && (cur_bad || cur_done)) begin
			active_q[vcnt_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (play_ok) begin
			eff_q[play_idx] <= effect_id;
			pos_q[play_idx] <= '0;
		end else if (cur_read) begin
			pos_q[vcnt_q] <= POS_W'(cur_pos_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cur_read;
			if (cmd.scan_start) begin
				vcnt_q <= '0;
			end else if (cmd.scan_step) begin
				vcnt_q <= vcnt_q + VIDX_W'(1);
			end
		end
	end

	assign sts.scan_last = (vcnt_q == VIDX_W'(NUM_VOICES - 1));

	// ---- sample memory
	logic                   ld_ok;
	logic [MEM_AW-1:0]      ld_addr;
	logic [MEM_AW-1:0]      rd_addr;
	logic signed [EXT_W-1:0] ld_ext;
	logic [SAMPLE_BITS-1:0] ld_word;
	logic [SAMPLE_BITS-1:0] rd_word;

	always_comb begin
		ld_ok   = cmd.do_load && ({1'b0, effect_id} < 4'(NUM_EFFECTS))
			&& ({2'b0, sample_addr} < 17'(MAX_LEN));
		ld_addr = MEM_AW'(effect_id) * MEM_AW'(MAX_LEN) + MEM_AW'(sample_addr);
		rd_addr = MEM_AW'(cur_eff) * MEM_AW'(MAX_LEN) + MEM_AW'(cur_pos);
		// narrow words keep the low bits, wide words sign-extend
		ld_ext  = EXT_W'(sample_data);
		ld_word = ld_ext[SAMPLE_BITS-1:0];
	end

	semx_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MEM_DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (ld_ok),
		.waddr (ld_addr),
		.wdata (ld_word),
		.re    (cur_read),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	// ---- accumulator and output register
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			acc_q <= '0;
		end else if (rd_valid_s1) begin
			acc_q <= acc_q + ACC_W'($signed(rd_word));
		end
	end

	logic signed [OUT_W-1:0] sat_val;

	always_comb begin
		if (acc_q > SAT_HI) begin
			sat_val = OUT_W'(SAT_HI);
		end else if (acc_q < SAT_LO) begin
			sat_val = OUT_W'(SAT_LO);
		end else begin
			sat_val = acc_q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= sat_val;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign mixed_sample  = out_q;

endmodule

[hdl/sound_effect_voice_mixer_top.sv]
// ----------------------------------------------------------------
// sound_effect_voice_mixer_top
// Polyphonic sample-playback mixer: sample loads, voice starts and
// ticks that sum every active voice into one saturated output.
// ----------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    opcode, effect_id, sample_addr, sample_data
//  out      output     out_valid/out_ready  mixed_sample
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Load and play requests are handled in the idle state; a tick passes the
//  accepting state, one scan step per voice slot (reading active voices),
//  a drain state for the last read to land, and the output load.
//  The output register frees the input side: new requests are taken while
//  a result waits. A tick finishing while the result is still held stalls.
//  Reset clears voices and length registers; sample memory is not cleared.
// ----------------------------------------------------------------
`include "assert_macros.svh"

module sound_effect_voice_mixer_top import semx_pkg::*; #(
	parameter int NUM_VOICES  = NUM_VOICES_DEF,
	parameter int NUM_EFFECTS = NUM_EFFECTS_DEF,
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OPCODE_W-1:0]      opcode,
	input  logic [EFF_ID_W-1:0]      effect_id,
	input  logic [ADDR_W-1:0]        sample_addr,
	input  logic signed [DATA_W-1:0] sample_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  mixed_sample,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [LEN_W-1:0]         cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	semx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	semx_dp #(
		.NUM_VOICES  (NUM_VOICES),
		.NUM_EFFECTS (NUM_EFFECTS),
		.MAX_LEN     (MAX_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.effect_id    (effect_id),
		.sample_addr  (sample_addr),
		.sample_data  (sample_data),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample)
	);

	// no request is taken while a tick walks the voices
	`SEMX_ASSERT_IMP(a_scan_blocks_in, clk, arst_n, cmd.scan_step, !in_ready)
	// an accepted tick starts the voice walk in the next cycle
	`SEMX_ASSERT_NXT(a_tick_starts_scan, clk, arst_n,
		in_valid && in_ready && opcode == OP_TICK, cmd.scan_step)
	// a result only shows up after the controller loaded it
	`SEMX_ASSERT_IMP(a_out_from_emit, clk, arst_n, $rose(out_valid), $past(cmd.emit))

endmodule
